[src/sled_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling LED matrix driver package
// Sizes, command codes, store access types and the shift word builder.
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam int MAX_COLS     = 1024;
    localparam int ROWS         = 8;
    localparam int WIN          = 8;
    localparam int COL_W        = $clog2(MAX_COLS);
    localparam int ROW_W        = $clog2(ROWS);
    localparam int WIN_W        = $clog2(WIN);
    localparam int LOAD_ROW_W   = ROW_W + 1;
    localparam int CNT_W        = COL_W + 2;
    localparam int WIDTH_W      = COL_W + 1;
    localparam int MEM_DEPTH    = ROWS * MAX_COLS;
    localparam int CMD_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int WORD_W       = 16;

    localparam logic [CMD_W-1:0]  CMD_LOAD     = 2'd0;
    localparam logic [CMD_W-1:0]  CMD_TICK     = 2'd1;
    localparam logic [CMD_W-1:0]  CMD_SCAN     = 2'd2;

    localparam logic [CHAR_W-1:0] LIT_CHAR     = 8'h6F;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             dot;
    } store_wr_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } store_rd_t;

    function automatic logic [WORD_W-1:0] make_word(input logic [ROW_W-1:0] r,
                                                    input logic [WIN_W-1:0] c);
        logic [7:0] row_mask;
        logic [7:0] col_mask;
        row_mask = ~(8'h80 >> r);
        col_mask = 8'h80 >> c;
        return {row_mask, col_mask};
    endfunction

endpackage

[src/sled_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying a command code and a pattern character.
// ----------------------------------------------------------------------------
interface sled_cmd_if import sled_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_byte;

    modport source (output valid, output cmd, output char_byte, input ready);
    modport sink   (input valid, input cmd, input char_byte, output ready);

endinterface

[src/sled_word_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift word channel
// Valid/ready channel carrying one matrix shift word and a frame end flag.
// ----------------------------------------------------------------------------
interface sled_word_if import sled_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] shift_word;
    logic              last;

    modport source (output valid, output shift_word, output last, input ready);
    modport sink   (input valid, input shift_word, input last, output ready);

endinterface

[src/sled_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern store
// Single-bit synchronous memory of ROWS x MAX_COLS dots with a per-row fill
// length, so that cells not yet written since reset read as dark.
// ----------------------------------------------------------------------------
module sled_store import sled_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  store_wr_t wr,
    input  store_rd_t rd,
    output logic      dot
);

    logic               mem [MEM_DEPTH];
    logic               data_reg;
    logic               hit_reg;
    logic [WIDTH_W-1:0] fill_reg [ROWS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[{wr.row, wr.col}] <= wr.dot;
        end
        if (rd.en)
        begin
            data_reg <= mem[{rd.row, rd.col}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                fill_reg[i] <= '0;
            end
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                fill_reg[wr.row] <= {1'b0, wr.col} + 1'b1;
            end
            if (rd.en)
            begin
                hit_reg <= ({1'b0, rd.col} < fill_reg[rd.row]);
            end
        end
    end

    assign dot = data_reg & hit_reg;

endmodule

[src/sled_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame scanner
// Walks the 8x8 window one store read per cycle unless stalled, holds back
// one lit word so the frame's final word can be flagged, and drives the output.
// ----------------------------------------------------------------------------
module sled_scan import sled_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH_W-1:0] width,
    input  logic [COL_W-1:0]   offset,
    input  logic               dot,
    output store_rd_t          rd,
    output logic               busy,
    sled_word_if.source        word_ch
);

    logic               running_reg, running_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [WIN_W-1:0]   j_reg, j_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [ROW_W-1:0]   s1_row_reg, s1_row_next;
    logic [WIN_W-1:0]   s1_j_reg, s1_j_next;
    logic               s1_final_reg, s1_final_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0]  pend_word_reg, pend_word_next;
    logic               flush_reg, flush_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic               out_last_reg, out_last_next;
    logic               out_free;
    logic               s1_take;
    logic [WIDTH_W-1:0] col_inc;

    always_comb
    begin
        running_next    = running_reg;
        row_next        = row_reg;
        j_next          = j_reg;
        col_next        = col_reg;
        s1_valid_next   = s1_valid_reg;
        s1_row_next     = s1_row_reg;
        s1_j_next       = s1_j_reg;
        s1_final_next   = s1_final_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        flush_next      = flush_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        rd              = '0;
        s1_take         = 1'b0;
        out_free        = !out_valid_reg || word_ch.ready;
        col_inc         = {1'b0, col_reg} + 1'b1;

        if (out_valid_reg && word_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (flush_reg)
        begin
            if (!pend_valid_reg)
            begin
                flush_next = 1'b0;
            end
            else if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = pend_word_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
                flush_next      = 1'b0;
            end
        end
        else if (s1_valid_reg)
        begin
            if (!dot)
            begin
                s1_take = 1'b1;
            end
            else if (!pend_valid_reg)
            begin
                s1_take         = 1'b1;
                pend_valid_next = 1'b1;
                pend_word_next  = make_word(s1_row_reg, s1_j_reg);
            end
            else if (out_free)
            begin
                s1_take        = 1'b1;
                out_valid_next = 1'b1;
                out_word_next  = pend_word_reg;
                out_last_next  = 1'b0;
                pend_word_next = make_word(s1_row_reg, s1_j_reg);
            end
            if (s1_take)
            begin
                s1_valid_next = 1'b0;
                if (s1_final_reg)
                begin
                    flush_next = 1'b1;
                end
            end
        end

        if (start)
        begin
            running_next = 1'b1;
            row_next     = '0;
            j_next       = '0;
            col_next     = offset;
        end
        else if (running_reg && (!s1_valid_reg || s1_take))
        begin
            rd.en         = 1'b1;
            rd.row        = row_reg;
            rd.col        = col_reg;
            s1_valid_next = 1'b1;
            s1_row_next   = row_reg;
            s1_j_next     = j_reg;
            s1_final_next = (row_reg == ROW_W'(ROWS - 1)) && (j_reg == WIN_W'(WIN - 1));
            if (j_reg == WIN_W'(WIN - 1))
            begin
                j_next   = '0;
                row_next = row_reg + 1'b1;
                col_next = offset;
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    running_next = 1'b0;
                end
            end
            else
            begin
                j_next = j_reg + 1'b1;
                if (col_inc == width)
                begin
                    col_next = '0;
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            running_reg    <= running_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            flush_reg      <= flush_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        j_reg         <= j_next;
        col_reg       <= col_next;
        s1_row_reg    <= s1_row_next;
        s1_j_reg      <= s1_j_next;
        s1_final_reg  <= s1_final_next;
        pend_word_reg <= pend_word_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    assign busy               = running_reg || s1_valid_reg || flush_reg;
    assign word_ch.valid      = out_valid_reg;
    assign word_ch.shift_word = out_word_reg;
    assign word_ch.last       = out_last_reg;

endmodule

[src/scrolling_led_matrix_driver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling LED matrix driver
// Loads an 8-row dot pattern from text, scrolls a window over it and emits
// one shift word for each lit dot of the 8x8 window.
// ----------------------------------------------------------------------------
//  Channel   Role    Payload                 Beat
//  cmd_ch    sink    cmd, char_byte          one command
//  word_ch   source  shift_word, last        one lit dot of a frame
//
//  Loads and ticks may follow back to back.
//  A scan reads the pattern memory once per window position, through the read
//  and hold stages; the command channel is held off until the last word has
//  reached the output register of the scanner.
//  A stall on word_ch pauses the scan; no words are lost or repeated.
//  Reset clears the per-row fill lengths at once; no clearing pass runs.
// ----------------------------------------------------------------------------
module scrolling_led_matrix_driver import sled_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sled_cmd_if.sink    cmd_ch,
    sled_word_if.source word_ch
);

    logic [LOAD_ROW_W-1:0] load_row_reg, load_row_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [WIDTH_W-1:0]    width_reg, width_next;
    logic [COL_W-1:0]      offset_reg, offset_next;
    logic                  accept;
    logic                  scan_busy;
    logic                  scan_start;
    logic                  scan_dot;
    logic [CNT_W-1:0]      count_sat;
    logic [WIDTH_W-1:0]    offset_inc;
    store_wr_t             store_wr;
    store_rd_t             store_rd;

    assign cmd_ch.ready = !scan_busy;
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign scan_start   = accept && (cmd_ch.cmd == CMD_SCAN) && (width_reg != '0);

    always_comb
    begin
        load_row_next = load_row_reg;
        count_next    = count_reg;
        width_next    = width_reg;
        offset_next   = offset_reg;
        store_wr      = '0;
        offset_inc    = {1'b0, offset_reg} + 1'b1;
        count_sat     = count_reg;

        if (count_reg < CNT_W'(2 * MAX_COLS))
        begin
            count_sat = count_reg + 1'b1;
        end

        if (accept)
        begin
            case (cmd_ch.cmd)
                CMD_LOAD:
                begin
                    if (load_row_reg < LOAD_ROW_W'(ROWS))
                    begin
                        if (cmd_ch.char_byte == NEWLINE_CHAR)
                        begin
                            load_row_next = load_row_reg + 1'b1;
                            count_next    = '0;
                        end
                        else
                        begin
                            count_next = count_sat;
                            if ((count_reg < CNT_W'(2 * MAX_COLS)) && !count_reg[0])
                            begin
                                store_wr.en  = 1'b1;
                                store_wr.row = load_row_reg[ROW_W-1:0];
                                store_wr.col = count_reg[COL_W:1];
                                store_wr.dot = (cmd_ch.char_byte == LIT_CHAR);
                            end
                            if (load_row_reg == LOAD_ROW_W'(ROWS - 1))
                            begin
                                width_next = count_sat[CNT_W-1:1];
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    if ((width_reg == '0) || (offset_inc == width_reg))
                    begin
                        offset_next = '0;
                    end
                    else
                    begin
                        offset_next = offset_inc[COL_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg <= '0;
            count_reg    <= '0;
            width_reg    <= '0;
            offset_reg   <= '0;
        end
        else
        begin
            load_row_reg <= load_row_next;
            count_reg    <= count_next;
            width_reg    <= width_next;
            offset_reg   <= offset_next;
        end
    end

    sled_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (store_wr),
        .rd    (store_rd),
        .dot   (scan_dot)
    );

    sled_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .width   (width_reg),
        .offset  (offset_reg),
        .dot     (scan_dot),
        .rd      (store_rd),
        .busy    (scan_busy),
        .word_ch (word_ch)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg != '0) |-> ({1'b0, offset_reg} < width_reg))
        else $error("Scroll offset is not below the pattern width.");

    assert property (@(posedge clk) disable iff (!rst_n)
        width_reg <= WIDTH_W'(MAX_COLS))
        else $error("Pattern width exceeds the column capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> !scan_busy && !store_rd.en)
        else $error("Pattern store written during a scan.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(scan_busy) |-> $past(accept && (cmd_ch.cmd == CMD_SCAN)))
        else $error("Scan started without an accepted scan command.");

endmodule

[tb/scrolling_led_matrix_driver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling LED matrix driver testbench
// A queue-fed driver sends pattern characters, scroll ticks and frame scans.
// A clocked monitor checks every shift word against frames predicted from the
// testbench's own copy of the dot pattern, fill position, width and scroll
// offset. Both channels idle at random, and the word side holds off for long
// stretches so that a scan backs up into the command channel. The pattern is
// built row by row, with the eighth row grown in small steps between scans,
// before the offset is walked round the wrap of the final width.
// ----------------------------------------------------------------------------
module scrolling_led_matrix_driver_tb;
    import sled_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [CMD_W-1:0]  op;
        logic [CHAR_W-1:0] ch;
        int                gap;
    } cmd_beat_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } dot_word_t;

    logic clk;
    logic rst_n;

    sled_cmd_if  cmd_ch ();
    sled_word_if word_ch ();

    scrolling_led_matrix_driver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .word_ch (word_ch)
    );

    // Predicted state of the block.
    bit                    lit_dots [ROWS][MAX_COLS];
    logic [LOAD_ROW_W-1:0] fill_row   = '0;
    logic [CNT_W-1:0]      fill_count = '0;
    logic [WIDTH_W-1:0]    dot_width  = '0;
    logic [COL_W-1:0]      scroll_pos = '0;
    dot_word_t             expected_words [$];

    cmd_beat_t pending_cmds [$];
    int        cmds_queued = 0;
    int        cmd_sent    = 0;
    int        cmd_beats   = 0;
    int        cmd_gap     = 0;
    int        idle_max    = 0;

    int word_beats      = 0;
    int word_beats_seen = 0;
    int word_stall      = 0;
    int stall_max       = 4;
    int hold_left       = 0;

    int mismatches = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch);
        int        base;
        int        col;
        bit        have;
        dot_word_t held;
        logic [7:0] row_bits;
        logic [7:0] col_bits;
        have = 1'b0;
        case (op)
            CMD_LOAD:
            begin
                if (fill_row < ROWS)
                begin
                    if (ch == NEWLINE_CHAR)
                    begin
                        fill_row++;
                        fill_count = '0;
                    end
                    else
                    begin
                        if (fill_count < 2 * MAX_COLS)
                        begin
                            if (!fill_count[0])
                                lit_dots[fill_row][fill_count >> 1] = (ch == LIT_CHAR);
                            fill_count++;
                        end
                        if (fill_row == ROWS - 1)
                            dot_width = WIDTH_W'(fill_count >> 1);
                    end
                end
            end
            CMD_TICK:
            begin
                if (dot_width == 0)
                    scroll_pos = '0;
                else
                    scroll_pos = COL_W'((int'(scroll_pos) % int'(dot_width) + 1)
                                        % int'(dot_width));
            end
            CMD_SCAN:
            begin
                if (dot_width != 0)
                begin
                    base = int'(scroll_pos) % int'(dot_width);
                    for (int r = 0; r < WIN; r++)
                    begin
                        for (int c = 0; c < WIN; c++)
                        begin
                            col = (c + base) % int'(dot_width);
                            if (lit_dots[r][col])
                            begin
                                if (have)
                                    expected_words.push_back(held);
                                row_bits  = 8'hFF ^ (8'h01 << (7 - r));
                                col_bits  = 8'h01 << (7 - c);
                                held.word = {row_bits, col_bits};
                                held.last = 1'b0;
                                have      = 1'b1;
                            end
                        end
                    end
                    if (have)
                    begin
                        held.last = 1'b1;
                        expected_words.push_back(held);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Command side: acceptance at the rising edge, drive at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            apply_command(cmd_ch.cmd, cmd_ch.char_byte);
            cmd_beats++;
        end
    end

    always @(negedge clk)
    begin : cmd_driver
        cmd_beat_t nxt;
        if (rst_n && cmd_beats == cmd_sent)
        begin
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                nxt = pending_cmds.pop_front();
                cmd_ch.valid     <= 1'b1;
                cmd_ch.cmd       <= nxt.op;
                cmd_ch.char_byte <= nxt.ch;
                cmd_sent++;
                cmd_gap = nxt.gap;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Word side: check each beat at the rising edge, pace ready at the falling edge.
    always @(posedge clk)
    begin : word_monitor
        dot_word_t want;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("word %h last %b with nothing pending",
                                          word_ch.shift_word, word_ch.last));
            else
            begin
                want = expected_words.pop_front();
                if (word_ch.shift_word !== want.word)
                    report_mismatch($sformatf("shift_word %h, predicted %h",
                                              word_ch.shift_word, want.word));
                if (word_ch.last !== want.last)
                    report_mismatch($sformatf("last %b on word %h, predicted %b",
                                              word_ch.last, want.word, want.last));
            end
            word_beats++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_beats != word_beats_seen)
            begin
                word_beats_seen = word_beats;
                if (word_beats_seen % 64 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: stall_max = 0;
                        1: stall_max = 4;
                        default: stall_max = 12;
                    endcase
                end
                word_stall = $urandom_range(0, stall_max);
                if (word_beats_seen == 20 || word_beats_seen == 600)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                word_ch.ready <= 1'b0;
            end
            else if (word_stall > 0)
            begin
                word_stall--;
                word_ch.ready <= 1'b0;
            end
            else
                word_ch.ready <= 1'b1;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch);
        cmd_beat_t item;
        item.op  = op;
        item.ch  = ch;
        item.gap = $urandom_range(0, idle_max);
        pending_cmds.push_back(item);
        cmds_queued++;
    endtask

    // Queues n pattern characters, each lit with the given percentage.
    task automatic queue_text(input int n, input int lit_pct);
        logic [CHAR_W-1:0] ch;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(1, 100) <= lit_pct)
                ch = LIT_CHAR;
            else
            begin
                do
                    ch = CHAR_W'($urandom_range(0, 255));
                while (ch == LIT_CHAR || ch == NEWLINE_CHAR);
            end
            queue_cmd(CMD_LOAD, ch);
        end
    endtask

    task automatic wait_drained();
        while (cmd_beats != cmds_queued || expected_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int ticks_to_edge;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = CMD_LOAD;
        cmd_ch.char_byte = '0;
        word_ch.ready    = 1'b0;
        rst_n            = 1'b0;

        // An empty pattern gives no words and keeps the offset at zero.
        idle_max = 3;
        queue_cmd(CMD_SCAN, 8'h00);
        queue_cmd(CMD_TICK, 8'hFF);
        queue_cmd(CMD_SCAN, 8'h55);
        queue_cmd(CMD_SPARE, 8'hFF);
        queue_cmd(CMD_SPARE, 8'h00);
        // First row: odd positions are skipped whatever they hold.
        queue_cmd(CMD_LOAD, LIT_CHAR);
        queue_cmd(CMD_LOAD, LIT_CHAR);
        queue_cmd(CMD_LOAD, LIT_CHAR);
        queue_cmd(CMD_LOAD, 8'h00);
        queue_cmd(CMD_LOAD, 8'hFF);
        queue_cmd(CMD_LOAD, 8'h6E);
        queue_cmd(CMD_LOAD, NEWLINE_CHAR);
        // Second row left empty.
        queue_cmd(CMD_LOAD, NEWLINE_CHAR);
        queue_cmd(CMD_SCAN, 8'hAA);
        queue_cmd(CMD_TICK, 8'h00);

        // Rows three to seven, of random length.
        for (int r = 2; r < ROWS - 1; r++)
        begin
            idle_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
            queue_text($urandom_range(0, 24), 50);
            if ($urandom_range(0, 1))
                queue_cmd(CMD_SCAN, CHAR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0)
                queue_cmd(CMD_TICK, CHAR_W'($urandom_range(0, 255)));
            queue_cmd(CMD_LOAD, NEWLINE_CHAR);
        end

        // The eighth row grows a little at a time, so narrow widths are scanned.
        for (int step = 0; step < 50; step++)
        begin
            if (step % 10 == 0)
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            queue_text($urandom_range(1, 2), 50);
            repeat ($urandom_range(0, 3))
                queue_cmd(CMD_TICK, CHAR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 6)
                queue_cmd(CMD_SCAN, CHAR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                queue_cmd(CMD_SPARE, CHAR_W'($urandom_range(0, 255)));
        end

        reset_done: begin
            repeat (2) @(posedge clk);
            @(negedge clk);
            rst_n = 1'b1;
        end

        // Walk the offset to just short of the wrap, then scan across it.
        wait_drained();
        ticks_to_edge = (int'(dot_width) - 3 - int'(scroll_pos) + int'(dot_width))
                        % int'(dot_width);
        idle_max = 0;
        for (int k = 0; k < ticks_to_edge; k++)
        begin
            queue_cmd(CMD_TICK, CHAR_W'($urandom_range(0, 255)));
            if (k % 16 == 15)
                queue_cmd(CMD_SCAN, CHAR_W'($urandom_range(0, 255)));
        end
        idle_max = 12;
        repeat (6)
        begin
            queue_cmd(CMD_SCAN, CHAR_W'($urandom_range(0, 255)));
            queue_cmd(CMD_TICK, CHAR_W'($urandom_range(0, 255)));
        end

        // Close the eighth row; every later load leaves the pattern alone.
        queue_cmd(CMD_LOAD, NEWLINE_CHAR);
        for (int k = 0; k < 110; k++)
        begin
            if (k % 25 == 0)
                idle_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_cmd(CMD_LOAD, CHAR_W'($urandom_range(0, 255)));
                4, 5:       queue_cmd(CMD_TICK, CHAR_W'($urandom_range(0, 255)));
                6, 7, 8:    queue_cmd(CMD_SCAN, CHAR_W'($urandom_range(0, 255)));
                default:    queue_cmd(CMD_SPARE, CHAR_W'($urandom_range(0, 255)));
            endcase
        end
        queue_cmd(CMD_SCAN, 8'hFF);

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #24_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/sled_pkg.sv
src/sled_cmd_if.sv
src/sled_word_if.sv
src/sled_store.sv
src/sled_scan.sv
src/scrolling_led_matrix_driver.sv
tb/scrolling_led_matrix_driver_tb.sv
